@@ rtl/npc_pkg.sv @@
// Shared types and constants for the nearest palette color search.
// No dependencies; imported by every module of the block.
`default_nettype none

package npc_pkg;

  // Operation codes carried on the input tuser bit
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } npc_op_e;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned IndexW = 8;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = SqW + 2;   // three squares summed

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } npc_rgb_t;

  // Tag that travels with each scanned entry down the distance pipeline
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [IndexW-1:0] idx;
  } npc_tag_t;

endpackage

`default_nettype wire

@@ rtl/npc_store.sv @@
// Palette store: one write port, one read port, registered read data.
// Depends on npc_pkg for the entry type.
`default_nettype none

module npc_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire                  clk_i,
  input  wire                  wr_en_i,
  input  wire [AddrW-1:0]      wr_addr_i,
  input  npc_pkg::npc_rgb_t    wr_data_i,
  input  wire                  rd_en_i,
  input  wire [AddrW-1:0]      rd_addr_i,
  output npc_pkg::npc_rgb_t    rd_data_o
);
  import npc_pkg::*;

  npc_rgb_t mem [Depth];
  npc_rgb_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/npc_dist.sv @@
// Squared RGB distance pipeline: abs difference, square, sum; one stage each.
// Depends on npc_pkg for the color and tag types.
`default_nettype none

module npc_dist (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  npc_pkg::npc_rgb_t          query_i,
  input  npc_pkg::npc_rgb_t          entry_i,
  input  npc_pkg::npc_tag_t          tag_i,
  output logic [npc_pkg::DistW-1:0]  dist_o,
  output npc_pkg::npc_tag_t          tag_o
);
  import npc_pkg::*;

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a, logic [ChanW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  npc_rgb_t         diff_d, diff_q;
  logic [SqW-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [DistW-1:0] dist_q;
  npc_tag_t         tag1_q, tag2_q, tag3_q;

  always_comb begin
    diff_d.red   = abs_diff(entry_i.red,   query_i.red);
    diff_d.green = abs_diff(entry_i.green, query_i.green);
    diff_d.blue  = abs_diff(entry_i.blue,  query_i.blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_r_q <= SqW'(diff_q.red)   * SqW'(diff_q.red);
    sq_g_q <= SqW'(diff_q.green) * SqW'(diff_q.green);
    sq_b_q <= SqW'(diff_q.blue)  * SqW'(diff_q.blue);
    dist_q <= DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  end

  assign dist_o = dist_q;
  assign tag_o  = tag3_q;

endmodule

`default_nettype wire

@@ rtl/nearest_palette_color.sv @@
// Nearest palette color search, top level: stream ports, scan sequencer and
// running minimum. Depends on npc_pkg, npc_store and npc_dist.
`default_nettype none

// A write beat (tuser = 0) stores red/green/blue into the entry named by
// entry_index and gives no result; indexes at or beyond PALETTE_ENTRIES
// are dropped. A query beat (tuser = 1) scans entries 0 up to
// min(PALETTE_ENTRIES, 256) - 1, one per cycle from the single read port of
// the palette store, and returns one beat holding the lowest index at the
// smallest squared RGB distance. After a query beat the input is held off
// while the store is read once per entry, the read and the three distance
// stages drain, and the result is loaded. The result load waits, and the
// input with it, for as long as an earlier result still sits unaccepted at
// the output. The result sits in an output register, so a write beat is
// accepted while a result waits. Entries never written read as whatever
// the store holds.

module nearest_palette_color #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
  input  wire [31:0]  s_axis_tdata_i,
  // tuser: [0] operation
  input  wire         s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // tdata: [7:0] best_index
  output logic [7:0]  m_axis_tdata_o
);
  import npc_pkg::*;

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned Scan  = (PALETTE_ENTRIES < 256) ? PALETTE_ENTRIES : 256;
  localparam int unsigned ScanW = $clog2(Scan);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Input beat unpacking
  logic [IndexW-1:0] s_entry_index;
  npc_rgb_t          s_color;
  logic              s_accept;
  logic              in_range;

  assign s_entry_index = s_axis_tdata_i[7:0];
  assign s_color.red   = s_axis_tdata_i[15:8];
  assign s_color.green = s_axis_tdata_i[23:16];
  assign s_color.blue  = s_axis_tdata_i[31:24];
  assign s_accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign in_range      = 32'(s_entry_index) < PALETTE_ENTRIES;

  // Sequencer state
  state_e            state_q, state_d;
  logic [ScanW-1:0]  issue_q, issue_d;
  logic              m_valid_q, m_valid_d;
  logic [IndexW-1:0] m_data_q, m_data_d;
  logic              rd_en;
  npc_tag_t          tag0, tag0_q;

  // Query color held for the whole scan
  npc_rgb_t          query_q;

  // Datapath
  npc_rgb_t          rd_data;
  logic [DistW-1:0]  entry_dist;
  npc_tag_t          tag3;
  logic [DistW-1:0]  min_q;
  logic [IndexW-1:0] best_q;

  always_comb begin
    state_d   = state_q;
    issue_d   = issue_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    rd_en     = 1'b0;
    tag0      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept && npc_op_e'(s_axis_tuser_i) == OP_QUERY) begin
          issue_d = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        tag0.valid = 1'b1;
        tag0.first = (issue_q == '0);
        tag0.last  = (issue_q == ScanW'(Scan - 1));
        tag0.idx   = IndexW'(issue_q);
        if (tag0.last) begin
          state_d = ST_DRAIN;
        end else begin
          issue_d = issue_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // best_q takes the last entry on the same edge
        if (tag3.valid && tag3.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = best_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      issue_q   <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
    end
  end

  // Tag lines up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
    end else begin
      tag0_q <= tag0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && npc_op_e'(s_axis_tuser_i) == OP_QUERY) begin
      query_q <= s_color;
    end
  end

  npc_store #(
    .Depth (PALETTE_ENTRIES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (s_accept && npc_op_e'(s_axis_tuser_i) == OP_WRITE && in_range),
    .wr_addr_i (AddrW'(s_entry_index)),
    .wr_data_i (s_color),
    .rd_en_i   (rd_en),
    .rd_addr_i (AddrW'(issue_q)),
    .rd_data_o (rd_data)
  );

  npc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_q),
    .entry_i (rd_data),
    .tag_i   (tag0_q),
    .dist_o  (entry_dist),
    .tag_o   (tag3)
  );

  // Running minimum; strict compare keeps the lowest index on ties, and
  // entry 0 always seeds the candidate.
  always_ff @(posedge clk_i) begin
    if (tag3.valid && (tag3.first || entry_dist < min_q)) begin
      min_q  <= entry_dist;
      best_q <= tag3.idx;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

`default_nettype wire

@@ bench/nearest_palette_color_tb.sv @@
// Self-checking bench for nearest_palette_color: stream driver and monitor,
// a palette shadow with a nearest-entry predictor, directed and random beats.
// Depends on npc_pkg and the nearest_palette_color RTL only.
module nearest_palette_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  // One input beat as the bench sees it before packing onto tdata/tuser
  typedef struct packed {
    npc_op_e           op;
    logic [IndexW-1:0] idx;
    npc_rgb_t          rgb;
  } palette_beat_t;

  localparam int unsigned NumEntries = 256;
  // A query holds the block while it scans all NumEntries entries; wait longer
  localparam int unsigned SettleCycles = 300;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data  = '0;
  logic        s_user  = 1'b0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;

  nearest_palette_color #(
    .PALETTE_ENTRIES(NumEntries)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue
    .s_axis_tuser_i (s_user),   // [0] operation
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)    // [7:0] best_index
  );

  // Beats waiting for the driver, and best indexes still owed by the block
  palette_beat_t     beat_queue[$];
  logic [IndexW-1:0] expected_index_q[$];

  // palette_model follows accepted beats; gen_palette follows generated ones
  // and is only used to aim queries at colors that are really in the store.
  npc_rgb_t palette_model [NumEntries];
  npc_rgb_t gen_palette   [NumEntries];

  int unsigned errors    = 0;
  int unsigned n_writes  = 0;
  int unsigned n_queries = 0;
  int unsigned n_checked = 0;
  int unsigned n_exact   = 0;
  int unsigned n_tied    = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #80_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic int unsigned chan_delta(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // Lowest index at minimum squared RGB distance. Running minimum starts at
  // 0x7fffffff so entry 0 always becomes the first candidate; strict < keeps
  // the lowest index on ties.
  function automatic logic [IndexW-1:0] nearest_entry(input npc_rgb_t c,
                                                      output bit exact,
                                                      output bit tied);
    int unsigned best_dist;
    int unsigned dr, dg, db, d;
    int          i;
    logic [IndexW-1:0] best;
    best_dist = 32'h7fff_ffff;
    best      = '0;
    tied      = 1'b0;
    for (i = 0; i < NumEntries; i++) begin
      dr = chan_delta(palette_model[i].red,   c.red);
      dg = chan_delta(palette_model[i].green, c.green);
      db = chan_delta(palette_model[i].blue,  c.blue);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_dist) begin
        best_dist = d;
        best      = 8'(i);
        tied      = 1'b0;
      end else if (d == best_dist) begin
        tied = 1'b1;
      end
    end
    exact = (best_dist == 0);
    return best;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length, random gaps in between. Each accepted
  // beat updates the palette shadow or queues the predicted best index.
  // ---------------------------------------------------------------------
  palette_beat_t drive_beat;
  int unsigned   burst_left = 0;
  int unsigned   gap_left   = 0;
  bit            hit_exact, hit_tied;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        if (drive_beat.op == OP_WRITE) begin
          palette_model[drive_beat.idx] = drive_beat.rgb;
          n_writes++;
        end else begin
          expected_index_q.push_back(nearest_entry(drive_beat.rgb, hit_exact, hit_tied));
          n_queries++;
          if (hit_exact) n_exact++;
          if (hit_tied)  n_tied++;
        end
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (beat_queue.size() > 0) begin
          drive_beat = beat_queue.pop_front();
          s_data  <= {drive_beat.rgb.blue, drive_beat.rgb.green,
                      drive_beat.rgb.red, drive_beat.idx};
          s_user  <= drive_beat.op;
          s_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a third of the bursts run straight into the next one
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction, and
  // stalls the output on a rotating 16-bit pattern that is redrawn now and
  // then. All-ones patterns give stretches with no backpressure.
  // ---------------------------------------------------------------------
  logic [15:0]       stall_pat  = '1;
  int unsigned       stall_hold = 0;
  logic [IndexW-1:0] want_index;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (expected_index_q.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with none expected: expected none, actual %0d",
                   $time, m_data);
        end else begin
          want_index = expected_index_q.pop_front();
          n_checked++;
          if (m_data !== want_index) begin
            errors++;
            $display("%0t ns: best_index mismatch: expected %0d, actual %0d",
                     $time, want_index, m_data);
          end
        end
      end
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(16, 96);
        // at least one ready bit per pattern
        stall_pat  = ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
      end else begin
        stall_hold--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      m_ready <= stall_pat[0];
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_write(input logic [IndexW-1:0] idx, input npc_rgb_t c);
    palette_beat_t b;
    b.op  = OP_WRITE;
    b.idx = idx;
    b.rgb = c;
    beat_queue.push_back(b);
    gen_palette[idx] = c;
  endtask

  task automatic push_query(input npc_rgb_t c);
    palette_beat_t b;
    b.op  = OP_QUERY;
    b.idx = 8'($urandom_range(0, 255));  // ignored by a query, kept noisy
    b.rgb = c;
    beat_queue.push_back(b);
  endtask

  // Coarse colors sit on a five-level grid, which makes ties common
  function automatic npc_rgb_t random_color(input bit coarse);
    logic [ChanW-1:0] levels [5];
    npc_rgb_t c;
    levels = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};
    if (coarse) begin
      c.red   = levels[$urandom_range(0, 4)];
      c.green = levels[$urandom_range(0, 4)];
      c.blue  = levels[$urandom_range(0, 4)];
    end else begin
      c = 24'($urandom());
    end
    return c;
  endfunction

  function automatic logic [ChanW-1:0] nudge(input logic [ChanW-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 8)) - 4;
    return (t < 0) ? 8'h00 : (t > 255) ? 8'hFF : 8'(t);
  endfunction

  // Mix of exact hits on stored colors, near misses and fresh colors
  function automatic npc_rgb_t query_color(input bit coarse);
    npc_rgb_t c;
    c = gen_palette[$urandom_range(0, NumEntries - 1)];
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        c.red   = nudge(c.red);
        c.green = nudge(c.green);
        c.blue  = nudge(c.blue);
      end
      2: c = random_color(1'b0);
      default: c = random_color(coarse);
    endcase
    return c;
  endfunction

  // Sender holds off until every queued beat is taken and every result is in
  task automatic wait_drained();
    while (beat_queue.size() != 0 || s_valid || expected_index_q.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int i, round, k;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every entry is written before the first query, since a query scans the
    // whole store and unwritten entries hold no defined color.
    for (i = 0; i < NumEntries; i++) push_write(8'(i), {8'hFF, 8'hFF, 8'hFF});

    // Directed: all entries equally far away, so entry 0 wins from the start
    push_query({8'h00, 8'h00, 8'h00});
    push_write(8'd0, {8'h00, 8'h00, 8'h00});
    push_query({8'h00, 8'h00, 8'h00});            // exact hit on entry 0
    push_query({8'hFF, 8'hFF, 8'hFF});            // many exact hits, lowest wins
    // two different colors at the same distance
    push_write(8'd5, {8'd100, 8'd100, 8'd100});
    push_write(8'd9, {8'd102, 8'd100, 8'd100});
    push_query({8'd101, 8'd100, 8'd100});
    // duplicate color, low and high index
    push_write(8'd10,  {8'd7, 8'd7, 8'd7});
    push_write(8'd200, {8'd7, 8'd7, 8'd7});
    push_query({8'd7, 8'd7, 8'd7});
    // exact hit on the last entry, then overwrite it and search near it
    push_write(8'd255, {8'd1, 8'd2, 8'd3});
    push_query({8'd1, 8'd2, 8'd3});
    push_write(8'd255, {8'hFF, 8'h00, 8'hFF});
    push_query({8'd250, 8'd0, 8'd250});
    push_query({8'h80, 8'h80, 8'h80});
    push_write(8'd128, {8'hAA, 8'h55, 8'hAA});
    push_query({8'h55, 8'hAA, 8'h55});
    push_query({8'hFF, 8'h00, 8'h00});
    push_query({8'h00, 8'hFF, 8'h00});
    push_query({8'h00, 8'h00, 8'hFF});
    wait_drained();

    // Random rounds; odd rounds use the coarse grid for frequent ties.
    // The sender drains between rounds.
    for (round = 0; round < 6; round++) begin
      for (k = 0; k < 280; k++) begin
        if ($urandom_range(0, 99) < 45)
          push_write(8'($urandom_range(0, 255)), random_color(round[0]));
        else
          push_query(query_color(round[0]));
      end
      wait_drained();
    end

    // Let any stray result beat show up before judging
    repeat (SettleCycles) @(negedge clk_i);

    $display("Run covered %0d palette writes and %0d nearest-color queries, %0d results checked.",
             n_writes, n_queries, n_checked);
    $display("Queries with an exact entry hit: %0d; with tied candidates at the minimum: %0d.",
             n_exact, n_tied);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/npc_pkg.sv
rtl/npc_store.sv
rtl/npc_dist.sv
rtl/nearest_palette_color.sv
bench/nearest_palette_color_tb.sv
